/* sv/etm_pkg.sv */
package etm_pkg;

   localparam int FRAC_BITS    = 14;
   localparam int ANG_FULL     = 23040;
   localparam int ANG_HALF     = 11520;
   localparam int ANG_QUARTER  = 5760;
   localparam int ANG_EIGHTH   = 2880;
   localparam longint unsigned PI_Q30 = 64'd3373259426;

   localparam int TAYLOR_TERMS = 7;
   localparam int TAYLOR_START = 5;
   localparam int SC_STAGES    = TAYLOR_START + 2 * TAYLOR_TERMS + 1;
   localparam int MAT_STAGES   = 3;
   localparam int PIPE_STAGES  = SC_STAGES + MAT_STAGES;

   typedef logic signed [31:0] q30_type;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
      logic signed [31:0] tx;
      logic signed [31:0] ty;
      logic signed [31:0] tz;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } pos_type;

   // Q30 product, rounded half away from zero
   function automatic q30_type qmul(input q30_type a, input q30_type b);
      logic        neg;
      logic [30:0] ma;
      logic [30:0] mb;
      logic [61:0] p;
      logic [31:0] r;
      neg = a[31] ^ b[31];
      ma  = a[31] ? 31'(-a) : 31'(a);
      mb  = b[31] ? 31'(-b) : 31'(b);
      p   = 62'(ma) * 62'(mb);
      r   = 32'((p + (62'd1 << 29)) >> 30);
      return neg ? q30_type'(-r) : q30_type'(r);
   endfunction

   // Q30 to Q2.FRAC_BITS, rounded and saturated to +-1.0
   function automatic logic [15:0] to_entry(input logic signed [32:0] v);
      logic        neg;
      logic [32:0] m;
      logic [33:0] r;
      logic [33:0] lim;
      neg = v[32];
      m   = neg ? 33'(-v) : 33'(v);
      r   = ((34'(m) << 1) >> (30 - FRAC_BITS)) + 34'd1;
      r   = r >> 1;
      lim = 34'd1 << FRAC_BITS;
      if (r > lim) r = lim;
      if (neg) r = -r;
      return r[15:0];
   endfunction

endpackage

/* sv/etm_if.sv */
interface etm_req_if;
   import etm_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface etm_rsp_if;
   import etm_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* sv/etm_sincos.sv */
module etm_sincos (
   input  logic                            clock,
   input  logic [etm_pkg::SC_STAGES-1:0]   en,
   input  logic signed [15:0]              angle,
   output etm_pkg::q30_type                sin_q30,
   output etm_pkg::q30_type                cos_q30
);
   import etm_pkg::*;

   localparam int XQ = int'(PI_Q30 / ANG_HALF);
   localparam int XR = int'(PI_Q30 - longint'(XQ) * ANG_HALF);
   localparam int XK = 39;
   localparam longint unsigned XM = ((64'd1 << XK) + ANG_HALF - 1) / ANG_HALF;
   localparam int LAST = SC_STAGES - 1;

   function automatic logic [30:0] clamp_one(input logic signed [31:0] v);
      if (v < 0) return 31'd0;
      if (v > 32'sd1073741824) return 31'd1 << 30;
      return 31'(v);
   endfunction

   logic signed [16:0] a17;
   logic [14:0]        r_in, r_ff;
   logic [12:0]        f;
   logic [11:0]        u_in, u_ff;
   logic [1:0]         q_in;
   logic               sw_in;
   logic [1:0]         q_ff  [1:SC_STAGES-2];
   logic               sw_ff [1:SC_STAGES-2];
   logic [29:0]        p1_ff;
   logic [24:0]        nn_ff;
   logic [50:0]        xprod;
   logic [29:0]        x_ff;
   logic [59:0]        xx;
   logic [29:0]        x2_ff [TAYLOR_START-1:LAST-1];
   logic [30:0]        ts_ff [TAYLOR_START-1:LAST-1];
   logic [30:0]        tc_ff [TAYLOR_START-1:LAST-1];
   logic signed [31:0] ss_ff [TAYLOR_START-1:LAST-1];
   logic signed [31:0] cc_ff [TAYLOR_START-1:LAST-1];
   logic [30:0]        s0, c0, sm, cm;
   q30_type            sin_ff, cos_ff;

   // angle wrap into one turn
   always_comb begin
      a17 = 17'(angle);
      if (a17 < -17'(ANG_FULL)) a17 = a17 + 17'(2 * ANG_FULL);
      else if (a17 < 17'sd0) a17 = a17 + 17'(ANG_FULL);
      else if (a17 >= 17'(ANG_FULL)) a17 = a17 - 17'(ANG_FULL);
      r_in = a17[14:0];
   end

   always_ff @(posedge clock) begin
      if (en[0]) r_ff <= r_in;
   end

   // quadrant and octant fold
   always_comb begin
      if (r_ff >= 15'(3 * ANG_QUARTER)) begin
         q_in = 2'd3;
         f    = 13'(r_ff - 15'(3 * ANG_QUARTER));
      end else if (r_ff >= 15'(2 * ANG_QUARTER)) begin
         q_in = 2'd2;
         f    = 13'(r_ff - 15'(2 * ANG_QUARTER));
      end else if (r_ff >= 15'(ANG_QUARTER)) begin
         q_in = 2'd1;
         f    = 13'(r_ff - 15'(ANG_QUARTER));
      end else begin
         q_in = 2'd0;
         f    = 13'(r_ff);
      end
      if (f <= 13'(ANG_EIGHTH)) begin
         u_in  = 12'(f);
         sw_in = 1'b0;
      end else begin
         u_in  = 12'(13'(ANG_QUARTER) - f);
         sw_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         u_ff     <= u_in;
         q_ff[1]  <= q_in;
         sw_ff[1] <= sw_in;
      end
   end

   for (genvar k = 2; k <= SC_STAGES - 2; k++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (en[k]) begin
            q_ff[k]  <= q_ff[k-1];
            sw_ff[k] <= sw_ff[k-1];
         end
      end
   end

   // offset to radians: integer part and remainder of pi/11520
   always_ff @(posedge clock) begin
      if (en[2]) begin
         p1_ff <= 30'(u_ff) * 30'(XQ);
         nn_ff <= 25'(u_ff) * 25'(XR) + 25'(ANG_QUARTER);
      end
   end

   assign xprod = 51'(nn_ff) * 51'(XM);

   always_ff @(posedge clock) begin
      if (en[3]) x_ff <= p1_ff + 30'(xprod >> XK);
   end

   assign xx = 60'(x_ff) * 60'(x_ff);

   always_ff @(posedge clock) begin
      if (en[4]) begin
         x2_ff[4] <= 30'((xx + (60'd1 << 29)) >> 30);
         ts_ff[4] <= 31'(x_ff);
         tc_ff[4] <= 31'd1 << 30;
         ss_ff[4] <= $signed({2'b00, x_ff});
         cc_ff[4] <= 32'sd1073741824;
      end
   end

   for (genvar g = 0; g < TAYLOR_TERMS; g++) begin : g_term
      localparam int SA = TAYLOR_START + 2 * g;
      localparam int SB = SA + 1;
      localparam int N  = g + 1;
      localparam int DS = (2 * N) * (2 * N + 1);
      localparam int DC = (2 * N - 1) * (2 * N);
      localparam int KS = 30 + $clog2(DS);
      localparam int KC = 30 + $clog2(DC);
      localparam longint unsigned MS = ((64'd1 << KS) + DS - 1) / DS;
      localparam longint unsigned MC = ((64'd1 << KC) + DC - 1) / DC;

      logic [61:0] pa_s, pa_c;
      logic [63:0] pb_s, pb_c;
      logic [30:0] tsn, tcn;

      assign pa_s = 62'(ts_ff[SA-1]) * 62'(x2_ff[SA-1]);
      assign pa_c = 62'(tc_ff[SA-1]) * 62'(x2_ff[SA-1]);

      always_ff @(posedge clock) begin
         if (en[SA]) begin
            ts_ff[SA] <= 31'((pa_s + (62'd1 << 29)) >> 30);
            tc_ff[SA] <= 31'((pa_c + (62'd1 << 29)) >> 30);
            x2_ff[SA] <= x2_ff[SA-1];
            ss_ff[SA] <= ss_ff[SA-1];
            cc_ff[SA] <= cc_ff[SA-1];
         end
      end

      // rounded divide by the factorial step
      assign pb_s = (64'(ts_ff[SA]) + 64'(DS / 2)) * 64'(MS);
      assign pb_c = (64'(tc_ff[SA]) + 64'(DC / 2)) * 64'(MC);
      assign tsn  = 31'(pb_s >> KS);
      assign tcn  = 31'(pb_c >> KC);

      always_ff @(posedge clock) begin
         if (en[SB]) begin
            ts_ff[SB] <= tsn;
            tc_ff[SB] <= tcn;
            x2_ff[SB] <= x2_ff[SA];
            if (N % 2 == 1) begin
               ss_ff[SB] <= ss_ff[SA] - $signed({1'b0, tsn});
               cc_ff[SB] <= cc_ff[SA] - $signed({1'b0, tcn});
            end else begin
               ss_ff[SB] <= ss_ff[SA] + $signed({1'b0, tsn});
               cc_ff[SB] <= cc_ff[SA] + $signed({1'b0, tcn});
            end
         end
      end
   end

   always_comb begin
      sm = clamp_one(ss_ff[LAST-1]);
      cm = clamp_one(cc_ff[LAST-1]);
      if (sw_ff[LAST-1]) begin
         s0 = cm;
         c0 = sm;
      end else begin
         s0 = sm;
         c0 = cm;
      end
   end

   always_ff @(posedge clock) begin
      if (en[LAST]) begin
         case (q_ff[LAST-1])
            2'd0: begin
               sin_ff <= q30_type'(s0);
               cos_ff <= q30_type'(c0);
            end
            2'd1: begin
               sin_ff <= q30_type'(c0);
               cos_ff <= -q30_type'(s0);
            end
            2'd2: begin
               sin_ff <= -q30_type'(s0);
               cos_ff <= -q30_type'(c0);
            end
            default: begin
               sin_ff <= -q30_type'(c0);
               cos_ff <= q30_type'(s0);
            end
         endcase
      end
   end

   assign sin_q30 = sin_ff;
   assign cos_q30 = cos_ff;

endmodule

/* sv/euler_to_homogeneous_matrix.sv */
// Euler angles (roll, pitch, yaw in 1/64 degree) plus a position to the top
// three rows of a 4x4 homogeneous transform, R = Rx(roll) * Ry(pitch) * Rz(yaw).
// req_bus carries one pose per beat; rsp_bus carries the nine Q2.14 rotation
// entries and the unchanged translation per beat. Both are valid/ready, a beat
// moves when valid and ready are high at a rising clock edge.
// From the request beat to the response being valid, a pose passes through
// 20 stages of angle fold and series sine/cosine (two stages per Taylor term,
// one multiply each), then 3 stages of matrix products and rounding.
// Throughput is one pose per cycle while rsp is not stalled. Every stage has
// its own valid bit and advances when empty or when the stage after it
// advances, so while rsp is stalled req_bus keeps accepting until all stages
// hold a beat; nothing is dropped or repeated.
// Synchronous active high reset empties the pipeline; the first request can
// be taken in the first cycle in which reset is low.
module euler_to_homogeneous_matrix (
   input logic       clock,
   input logic       reset,
   etm_req_if.sink   req_bus,
   etm_rsp_if.source rsp_bus
);
   import etm_pkg::*;

   localparam int M0 = SC_STAGES;
   localparam int M1 = SC_STAGES + 1;
   localparam int M2 = SC_STAGES + 2;

   logic [PIPE_STAGES-1:0] v_ff;
   logic [PIPE_STAGES-1:0] en;
   pos_type                pos_ff [0:PIPE_STAGES-1];
   q30_type                sr, cr, sp, cp, sy, cy;
   q30_type srsp_ff, crsp_ff, cpcy_ff, cpsy_ff, crsy_ff, crcy_ff;
   q30_type srcp_ff, srsy_ff, srcy_ff, crcp_ff, sp0_ff;
   q30_type srspcy_ff, srspsy_ff, crspcy_ff, crspsy_ff;
   q30_type cpcy1_ff, cpsy1_ff, crsy1_ff, crcy1_ff;
   q30_type srcp1_ff, srsy1_ff, srcy1_ff, crcp1_ff, sp1_ff;
   q30_type cy_d, sy_d;
   rsp_type out_ff;

   always_comb begin
      en[PIPE_STAGES-1] = ~v_ff[PIPE_STAGES-1] | rsp_bus.ready;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         en[i] = ~v_ff[i] | en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= req_bus.valid;
         for (int i = 1; i < PIPE_STAGES; i++) begin
            if (en[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   assign req_bus.ready = en[0] & ~reset;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pos_ff[0].x <= req_bus.data.pos_x;
         pos_ff[0].y <= req_bus.data.pos_y;
         pos_ff[0].z <= req_bus.data.pos_z;
      end
   end

   for (genvar k = 1; k < PIPE_STAGES; k++) begin : g_pos
      always_ff @(posedge clock) begin
         if (en[k]) pos_ff[k] <= pos_ff[k-1];
      end
   end

   etm_sincos u_roll (
      .clock   (clock),
      .en      (en[SC_STAGES-1:0]),
      .angle   (req_bus.data.roll_angle),
      .sin_q30 (sr),
      .cos_q30 (cr)
   );

   etm_sincos u_pitch (
      .clock   (clock),
      .en      (en[SC_STAGES-1:0]),
      .angle   (req_bus.data.pitch_angle),
      .sin_q30 (sp),
      .cos_q30 (cp)
   );

   etm_sincos u_yaw (
      .clock   (clock),
      .en      (en[SC_STAGES-1:0]),
      .angle   (req_bus.data.yaw_angle),
      .sin_q30 (sy),
      .cos_q30 (cy)
   );

   always_ff @(posedge clock) begin
      if (en[M0]) begin
         srsp_ff <= qmul(sr, sp);
         crsp_ff <= qmul(cr, sp);
         cpcy_ff <= qmul(cp, cy);
         cpsy_ff <= qmul(cp, sy);
         crsy_ff <= qmul(cr, sy);
         crcy_ff <= qmul(cr, cy);
         srcp_ff <= qmul(sr, cp);
         srsy_ff <= qmul(sr, sy);
         srcy_ff <= qmul(sr, cy);
         crcp_ff <= qmul(cr, cp);
         sp0_ff  <= sp;
      end
   end

   // cos/sin of yaw held one more stage for the second product level
   always_ff @(posedge clock) begin
      if (en[M0]) begin
         cy_d <= cy;
         sy_d <= sy;
      end
   end

   always_ff @(posedge clock) begin
      if (en[M1]) begin
         srspcy_ff <= qmul(srsp_ff, cy_d);
         srspsy_ff <= qmul(srsp_ff, sy_d);
         crspcy_ff <= qmul(crsp_ff, cy_d);
         crspsy_ff <= qmul(crsp_ff, sy_d);
         cpcy1_ff  <= cpcy_ff;
         cpsy1_ff  <= cpsy_ff;
         crsy1_ff  <= crsy_ff;
         crcy1_ff  <= crcy_ff;
         srcp1_ff  <= srcp_ff;
         srsy1_ff  <= srsy_ff;
         srcy1_ff  <= srcy_ff;
         crcp1_ff  <= crcp_ff;
         sp1_ff    <= sp0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[M2]) begin
         out_ff.m00 <= to_entry(33'(cpcy1_ff));
         out_ff.m01 <= to_entry(-33'(cpsy1_ff));
         out_ff.m02 <= to_entry(33'(sp1_ff));
         out_ff.m10 <= to_entry(33'(srspcy_ff) + 33'(crsy1_ff));
         out_ff.m11 <= to_entry(33'(crcy1_ff) - 33'(srspsy_ff));
         out_ff.m12 <= to_entry(-33'(srcp1_ff));
         out_ff.m20 <= to_entry(33'(srsy1_ff) - 33'(crspcy_ff));
         out_ff.m21 <= to_entry(33'(crspsy_ff) + 33'(srcy1_ff));
         out_ff.m22 <= to_entry(33'(crcp1_ff));
         out_ff.tx  <= pos_ff[M1].x;
         out_ff.ty  <= pos_ff[M1].y;
         out_ff.tz  <= pos_ff[M1].z;
      end
   end

   assign rsp_bus.valid = v_ff[PIPE_STAGES-1];
   assign rsp_bus.data  = out_ff;

endmodule

/* tb/tb_euler_to_homogeneous_matrix.sv */
module tb_euler_to_homogeneous_matrix;
   timeunit 1ns;
   timeprecision 1ps;
   import etm_pkg::*;

   localparam int IDLE_LIMIT  = 4000;
   localparam int RANDOM_POSES = 1800;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      req_type pose;
      logic    check_known;
      rsp_type known;
   } pose_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   etm_req_if req_bus ();
   etm_rsp_if rsp_bus ();

   euler_to_homogeneous_matrix uut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rsp_type     pending_matrices[$];
   pose_row_type directed_rows[$];
   int          mismatch_count = 0;
   int          poses_sent = 0;
   int          matrices_seen = 0;
   int          idle_cycles = 0;
   logic        rsp_stall_mode = 1'b0;

   // Q30 signed product, half away from zero
   function automatic longint q30_product(input longint a, input longint b);
      logic            neg;
      longint unsigned ma;
      longint unsigned mb;
      longint unsigned p;
      neg = (a < 0) != (b < 0);
      ma  = a < 0 ? -a : a;
      mb  = b < 0 ? -b : b;
      p   = (ma * mb + 64'd536870912) >> 30;
      return neg ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint unsigned unit_clamp(input longint v);
      if (v < 0) return 0;
      if (v > 64'd1073741824) return 64'd1073741824;
      return v;
   endfunction

   function automatic void octant_sin_cos(input int unsigned u,
                                          output longint unsigned s,
                                          output longint unsigned c);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned ts;
      longint unsigned tc;
      longint unsigned ds;
      longint unsigned dc;
      longint          ss;
      longint          cc;
      x  = (longint'(u) * PI_Q30 + ANG_HALF / 2) / ANG_HALF;
      x2 = (x * x + 64'd536870912) >> 30;
      ts = x;
      tc = 64'd1073741824;
      ss = x;
      cc = 64'd1073741824;
      for (int n = 1; n <= 7; n++) begin
         ds = (2 * n) * (2 * n + 1);
         dc = (2 * n - 1) * (2 * n);
         ts = (ts * x2 + 64'd536870912) >> 30;
         ts = (ts + ds / 2) / ds;
         tc = (tc * x2 + 64'd536870912) >> 30;
         tc = (tc + dc / 2) / dc;
         if (n % 2 == 1) begin
            ss -= longint'(ts);
            cc -= longint'(tc);
         end else begin
            ss += longint'(ts);
            cc += longint'(tc);
         end
      end
      s = unit_clamp(ss);
      c = unit_clamp(cc);
   endfunction

   function automatic void angle_sin_cos(input logic signed [15:0] angle,
                                         output longint s, output longint c);
      int              r;
      int unsigned     quadrant;
      int unsigned     offset;
      longint unsigned s0;
      longint unsigned c0;
      r = int'(angle) % ANG_FULL;
      if (r < 0) r += ANG_FULL;
      quadrant = r / ANG_QUARTER;
      offset   = r % ANG_QUARTER;
      if (offset <= ANG_EIGHTH) octant_sin_cos(offset, s0, c0);
      else octant_sin_cos(ANG_QUARTER - offset, c0, s0);
      case (quadrant)
         0: begin s = s0;  c = c0;  end
         1: begin s = c0;  c = -longint'(s0); end
         2: begin s = -longint'(s0); c = -longint'(c0); end
         default: begin s = -longint'(c0); c = s0; end
      endcase
   endfunction

   function automatic logic [15:0] q30_to_entry(input longint v);
      logic            neg;
      longint unsigned m;
      longint unsigned lim;
      neg = v < 0;
      m   = neg ? -v : v;
      lim = 64'd1 << FRAC_BITS;
      if (30 - FRAC_BITS > 0) m = (m + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      if (m > lim) m = lim;
      return neg ? 16'(-longint'(m)) : 16'(m);
   endfunction

   function automatic rsp_type pose_to_transform(input req_type p);
      rsp_type t;
      longint  sr, cr, sp, cp, sy, cy, srsp, crsp;
      angle_sin_cos(p.roll_angle, sr, cr);
      angle_sin_cos(p.pitch_angle, sp, cp);
      angle_sin_cos(p.yaw_angle, sy, cy);
      srsp  = q30_product(sr, sp);
      crsp  = q30_product(cr, sp);
      t.m00 = q30_to_entry(q30_product(cp, cy));
      t.m01 = q30_to_entry(-q30_product(cp, sy));
      t.m02 = q30_to_entry(sp);
      t.m10 = q30_to_entry(q30_product(srsp, cy) + q30_product(cr, sy));
      t.m11 = q30_to_entry(q30_product(cr, cy) - q30_product(srsp, sy));
      t.m12 = q30_to_entry(-q30_product(sr, cp));
      t.m20 = q30_to_entry(q30_product(sr, sy) - q30_product(crsp, cy));
      t.m21 = q30_to_entry(q30_product(crsp, sy) + q30_product(sr, cy));
      t.m22 = q30_to_entry(q30_product(cr, cp));
      t.tx  = p.pos_x;
      t.ty  = p.pos_y;
      t.tz  = p.pos_z;
      return t;
   endfunction

   task automatic compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic add_row(input int r, input int p, input int y,
                          input int x, input int yy, input int z, input logic known_ok);
      pose_row_type row;
      row.pose        = '{16'(r), 16'(p), 16'(y), 32'(x), 32'(yy), 32'(z)};
      row.check_known = known_ok;
      row.known       = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                          16'sd0, 16'sd0, 16'sd16384, 32'(x), 32'(yy), 32'(z)};
      directed_rows.push_back(row);
   endtask

   function automatic req_type random_pose();
      req_type p;
      int      mode;
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
         p.roll_angle  = 16'($urandom);
         p.pitch_angle = 16'($urandom);
         p.yaw_angle   = 16'($urandom);
      end else if (mode == 1) begin
         p.roll_angle  = 16'(ANG_EIGHTH * $urandom_range(0, 16) - ANG_FULL);
         p.pitch_angle = 16'(ANG_EIGHTH * $urandom_range(0, 16) - ANG_FULL);
         p.yaw_angle   = 16'(ANG_EIGHTH * $urandom_range(0, 16) - ANG_FULL);
      end else begin
         p.roll_angle  = 16'(int'($urandom_range(0, 2 * ANG_FULL)) - ANG_FULL);
         p.pitch_angle = 16'(int'($urandom_range(0, 2 * ANG_FULL)) - ANG_FULL);
         p.yaw_angle   = 16'(int'($urandom_range(0, 2 * ANG_FULL)) - ANG_FULL);
      end
      p.pos_x = $urandom;
      p.pos_y = $urandom;
      p.pos_z = $urandom;
      return p;
   endfunction

   task automatic send_pose(input req_type p);
      req_bus.valid <= 1'b1;
      req_bus.data  <= p;
      do @(posedge clock); while (!req_bus.ready);
      pending_matrices.push_back(pose_to_transform(p));
      poses_sent++;
      @(negedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         matrices_seen++;
         if (pending_matrices.size() == 0) begin
            $error("response beat with no pose pending");
            mismatch_count++;
         end else begin
            want = pending_matrices.pop_front();
            compare_field("m00", want.m00, rsp_bus.data.m00);
            compare_field("m01", want.m01, rsp_bus.data.m01);
            compare_field("m02", want.m02, rsp_bus.data.m02);
            compare_field("m10", want.m10, rsp_bus.data.m10);
            compare_field("m11", want.m11, rsp_bus.data.m11);
            compare_field("m12", want.m12, rsp_bus.data.m12);
            compare_field("m20", want.m20, rsp_bus.data.m20);
            compare_field("m21", want.m21, rsp_bus.data.m21);
            compare_field("m22", want.m22, rsp_bus.data.m22);
            compare_field("tx", want.tx, rsp_bus.data.tx);
            compare_field("ty", want.ty, rsp_bus.data.ty);
            compare_field("tz", want.tz, rsp_bus.data.tz);
         end
      end
   end

   // receiver: alternating stretches of free flow and random stalls
   int stall_phase = 0;
   always @(negedge clock) begin
      if (stall_phase == 0) begin
         stall_phase    <= $urandom_range(5, 60);
         rsp_stall_mode <= $urandom_range(0, 2) != 0;
      end else begin
         stall_phase <= stall_phase - 1;
      end
      rsp_bus.ready <= rsp_stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[euler_to_homogeneous_matrix] ERROR");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      pose_row_type row;
      rsp_type      want;
      int           burst;
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      rsp_bus.ready = 1'b0;

      add_row(0, 0, 0, 0, 0, 0, 1'b1);
      add_row(ANG_FULL, -ANG_FULL, 0, 32'h7fffffff, 32'h80000000, -1, 1'b1);
      add_row(32767, -32768, 0, 1, -1, 0, 1'b0);
      add_row(-32768, 32767, -32768, 0, 0, 0, 1'b0);
      add_row(ANG_QUARTER, 0, 0, 5, 6, 7, 1'b0);
      add_row(0, ANG_QUARTER, 0, 5, 6, 7, 1'b0);
      add_row(0, 0, ANG_QUARTER, 5, 6, 7, 1'b0);
      add_row(ANG_EIGHTH, ANG_EIGHTH, ANG_EIGHTH, 0, 0, 0, 1'b0);
      add_row(ANG_EIGHTH + 1, ANG_EIGHTH - 1, -ANG_EIGHTH, 0, 0, 0, 1'b0);
      add_row(ANG_HALF, ANG_HALF, ANG_HALF, 0, 0, 0, 1'b0);
      add_row(-ANG_HALF, 3 * ANG_QUARTER, -ANG_QUARTER, 0, 0, 0, 1'b0);
      add_row(1, -1, 1, 0, 0, 0, 1'b0);
      add_row(ANG_FULL - 1, 1 - ANG_FULL, 17280, 0, 0, 0, 1'b0);
      add_row(16'h5555, 16'haaaa, 16'h5555, 32'h55555555, 32'haaaaaaaa, 32'h55555555, 1'b0);
      add_row(16'haaaa, 16'h5555, 16'haaaa, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 1'b0);
      add_row(1920, 3840, 960, 0, 0, 0, 1'b0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.check_known) begin
            want = pose_to_transform(row.pose);
            if (want != row.known) begin
               $error("predictor disagrees with typed row %0d", i);
               mismatch_count++;
            end
         end
         send_pose(row.pose);
      end

      pause_sender(1);
      while (pending_matrices.size() != 0) @(negedge clock);

      while (poses_sent < directed_rows.size() + RANDOM_POSES) begin
         burst = $urandom_range(1, 40);
         repeat (burst) send_pose(random_pose());
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
      end
      req_bus.valid <= 1'b0;

      while (pending_matrices.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d poses (wrapped, octant, quadrant and random angles), %0d matrices",
               poses_sent, matrices_seen);
      if (mismatch_count == 0 && pending_matrices.size() == 0)
         $display("[euler_to_homogeneous_matrix] OK");
      else
         $display("[euler_to_homogeneous_matrix] ERROR");
      $finish;
   end
endmodule
